// ===== src/tsms_pkg.sv =====
// tsms_pkg: shared types and constants for the timestamp text parser
// no dependencies; used by tsms_close, tsms_final and the top level
package tsms_pkg;

    localparam int CHAR_W  = 8;
    localparam int MS_W    = 40;
    localparam int PART_W  = 3;
    localparam int FDIG_W  = 2;
    localparam int FVAL_W  = 10;
    localparam int DIGIT_W = 4;

    // part limits: three parts allowed, counter stops at four
    localparam int MAX_PARTS   = 3;
    localparam int PART_SAT    = 4;
    localparam int FRAC_DIGITS = 3;

    localparam int BASE_TEN   = 10;
    localparam int BASE_SIXTY = 60;
    localparam int MS_PER_SEC = 1000;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;

    typedef struct packed {
        logic              fraction_seen;
        logic              bad_character;
        logic              too_large;
        logic              empty_part_seen;
        logic [PART_W-1:0] part_count;
    } flags_t;

endpackage

// ===== src/tsms_close.sv =====
// tsms_close: closes one time part, folding the segment into the base-60 total
// depends on tsms_pkg
module tsms_close #(
    parameter int TIME_BITS = 40
) (
    input  logic [TIME_BITS-1:0] seconds,
    input  logic [TIME_BITS:0]   segment,
    input  logic                 segment_empty,
    input  tsms_pkg::flags_t     flags_in,
    output logic [TIME_BITS-1:0] seconds_out,
    output tsms_pkg::flags_t     flags_out
);

    localparam int WW = TIME_BITS + 7;

    logic [WW-1:0] total_wide;
    logic          over;

    // seconds * 60 + segment; segment at saturation already exceeds the limit
    assign total_wide = {7'd0, seconds} * WW'(tsms_pkg::BASE_SIXTY)
                      + {6'd0, segment};
    assign over = |total_wide[WW-1:TIME_BITS];

    always_comb
    begin
        seconds_out = seconds;
        flags_out   = flags_in;
        if (segment_empty)
        begin
            flags_out.empty_part_seen = 1'b1;
        end
        if (flags_in.part_count < tsms_pkg::PART_W'(tsms_pkg::MAX_PARTS))
        begin
            if (over)
            begin
                flags_out.too_large = 1'b1;
            end
            else
            begin
                seconds_out = total_wide[TIME_BITS-1:0];
            end
        end
        if (flags_in.part_count < tsms_pkg::PART_W'(tsms_pkg::PART_SAT))
        begin
            flags_out.part_count = flags_in.part_count + 1'b1;
        end
    end

endmodule

// ===== src/tsms_final.sv =====
// tsms_final: judges a finished text and scales it to milliseconds
// two pipeline stages plus the output register; depends on tsms_pkg, tsms_close
module tsms_final #(
    parameter int TIME_BITS = 40
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fin_valid,
    output logic                        fin_ready,
    input  logic [TIME_BITS-1:0]        fin_seconds,
    input  logic [TIME_BITS:0]          fin_segment,
    input  logic                        fin_segment_empty,
    input  tsms_pkg::flags_t            fin_flags,
    input  logic [tsms_pkg::FDIG_W-1:0] fin_fdig,
    input  logic [tsms_pkg::FVAL_W-1:0] fin_fval,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        valid_res,
    output logic [tsms_pkg::MS_W-1:0]   milliseconds
);

    localparam int MW = TIME_BITS + 10;

    // judge stage
    logic                        s2_valid_reg;
    logic [TIME_BITS-1:0]        s2_seconds_reg;
    logic [TIME_BITS:0]          s2_segment_reg;
    logic                        s2_segment_empty_reg;
    tsms_pkg::flags_t            s2_flags_reg;
    logic [tsms_pkg::FDIG_W-1:0] s2_fdig_reg;
    logic [tsms_pkg::FVAL_W-1:0] s2_fval_reg;

    // scale stage
    logic                        s3_valid_reg;
    logic [TIME_BITS-1:0]        s3_seconds_reg;
    logic [tsms_pkg::FVAL_W-1:0] s3_frac_reg;
    logic                        s3_ok_reg;

    logic                        out_valid_reg;
    logic                        valid_res_reg;
    logic [tsms_pkg::MS_W-1:0]   ms_reg;

    logic                        out_free;
    logic                        s3_adv;
    logic                        s2_adv;

    logic [TIME_BITS-1:0]        cl_seconds;
    tsms_pkg::flags_t            cl_flags;

    logic [TIME_BITS-1:0]        s3_seconds_next;
    logic [tsms_pkg::FVAL_W-1:0] s3_frac_next;
    tsms_pkg::flags_t            judge_flags;
    logic                        s3_ok_next;

    logic [MW-1:0]               ms_wide;
    logic                        ok_final;

    assign out_free  = !out_valid_reg || out_ready;
    assign s3_adv    = !s3_valid_reg || out_free;
    assign s2_adv    = !s2_valid_reg || s3_adv;
    assign fin_ready = s2_adv;

    tsms_close #(
        .TIME_BITS(TIME_BITS)
    ) u_close (
        .seconds      (s2_seconds_reg),
        .segment      (s2_segment_reg),
        .segment_empty(s2_segment_empty_reg),
        .flags_in     (s2_flags_reg),
        .seconds_out  (cl_seconds),
        .flags_out    (cl_flags)
    );

    // with a fraction mark the last segment is milliseconds, else one more part
    always_comb
    begin
        if (s2_flags_reg.fraction_seen)
        begin
            s3_seconds_next = s2_seconds_reg;
            judge_flags     = s2_flags_reg;
            case (s2_fdig_reg)
                2'd0:    s3_frac_next = '0;
                2'd1:    s3_frac_next = s2_fval_reg * tsms_pkg::FVAL_W'(100);
                2'd2:    s3_frac_next = s2_fval_reg * tsms_pkg::FVAL_W'(tsms_pkg::BASE_TEN);
                default: s3_frac_next = s2_fval_reg;
            endcase
        end
        else
        begin
            s3_seconds_next = cl_seconds;
            judge_flags     = cl_flags;
            s3_frac_next    = '0;
        end
        s3_ok_next = !judge_flags.bad_character && !judge_flags.too_large
                  && !judge_flags.empty_part_seen
                  && (judge_flags.part_count != '0)
                  && (judge_flags.part_count <= tsms_pkg::PART_W'(tsms_pkg::MAX_PARTS));
    end

    assign ms_wide  = {10'd0, s3_seconds_reg} * MW'(tsms_pkg::MS_PER_SEC)
                    + MW'(s3_frac_reg);
    assign ok_final = s3_ok_reg && !(|ms_wide[MW-1:TIME_BITS]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_adv)
            begin
                s2_valid_reg <= fin_valid;
            end
            if (s3_adv)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s2_seconds_reg       <= fin_seconds;
            s2_segment_reg       <= fin_segment;
            s2_segment_empty_reg <= fin_segment_empty;
            s2_flags_reg         <= fin_flags;
            s2_fdig_reg          <= fin_fdig;
            s2_fval_reg          <= fin_fval;
        end
        if (s3_adv)
        begin
            s3_seconds_reg <= s3_seconds_next;
            s3_frac_reg    <= s3_frac_next;
            s3_ok_reg      <= s3_ok_next;
        end
        if (out_free)
        begin
            valid_res_reg <= ok_final;
            ms_reg        <= ok_final ? ms_wide[tsms_pkg::MS_W-1:0] : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign valid_res    = valid_res_reg;
    assign milliseconds = ms_reg;

endmodule

// ===== src/timestamp_text_to_milliseconds.sv =====
// timestamp_text_to_milliseconds: top level of the timestamp text parser
// input register and character accumulator; depends on tsms_pkg, tsms_close, tsms_final
//
// usage
//   input channel (in_valid / in_ready) carries one word per character:
//   character, char_present (0 means no character in this word) and last,
//   which marks the final word of one timestamp text such as 01:02:03,456
//   output channel (out_valid / out_ready) carries one word per text:
//   valid_res and milliseconds (zero when the text is rejected)
//   throughput: one input word per cycle, sustained across text boundaries while each
//   last word finds a free final stage; the result word passes the input register,
//   judge stage, scale stage and output register after its last input word is accepted
//   the per-character update is one constant multiply-add on the segment
//   and a base-60 fold; the final x1000 scaling has a stage of its own
//   reset clears the accumulator and empties all pipeline stages
//   a stalled receiver fills the output register and the two final stages;
//   characters keep flowing until a last word has no free stage behind it,
//   then in_ready drops until the receiver takes a word
module timestamp_text_to_milliseconds #(
    parameter int TIME_BITS = 40
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tsms_pkg::CHAR_W-1:0] character,
    input  logic                        char_present,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        valid_res,
    output logic [tsms_pkg::MS_W-1:0]   milliseconds
);

    localparam int SW = TIME_BITS + 4;

    // input register
    logic                        in_valid_reg;
    logic [tsms_pkg::CHAR_W-1:0] char_reg;
    logic                        present_reg;
    logic                        last_reg;

    // accumulator state for the text in progress
    logic [TIME_BITS-1:0]        seconds_reg;
    logic [TIME_BITS:0]          segment_reg;   // top bit set means saturated
    logic                        segment_empty_reg;
    tsms_pkg::flags_t            flags_reg;
    logic [tsms_pkg::FDIG_W-1:0] fdig_reg;
    logic [tsms_pkg::FVAL_W-1:0] fval_reg;

    // state after the current character
    logic [TIME_BITS-1:0]        seconds_next;
    logic [TIME_BITS:0]          segment_next;
    logic                        segment_empty_next;
    tsms_pkg::flags_t            flags_next;
    logic [tsms_pkg::FDIG_W-1:0] fdig_next;
    logic [tsms_pkg::FVAL_W-1:0] fval_next;

    logic                        fin_ready;
    logic                        process;
    logic [tsms_pkg::DIGIT_W-1:0] digit;
    logic [SW-1:0]               segment_wide;
    logic [TIME_BITS:0]          segment_digit;

    logic [TIME_BITS-1:0]        cl_seconds;
    tsms_pkg::flags_t            cl_flags;

    // a word leaves the input register unless it ends a text with no room behind
    assign process  = in_valid_reg && (!last_reg || fin_ready);
    assign in_ready = !in_valid_reg || process;

    // digit append: segment * 10 + d, saturating just above the limit
    assign digit        = tsms_pkg::DIGIT_W'(char_reg - tsms_pkg::CHAR_ZERO);
    assign segment_wide = {4'd0, segment_reg[TIME_BITS-1:0]} * SW'(tsms_pkg::BASE_TEN)
                        + SW'(digit);
    assign segment_digit = (segment_reg[TIME_BITS] || (|segment_wide[SW-1:TIME_BITS]))
                         ? {1'b1, {TIME_BITS{1'b0}}}
                         : {1'b0, segment_wide[TIME_BITS-1:0]};

    // part closing on a separator
    tsms_close #(
        .TIME_BITS(TIME_BITS)
    ) u_close (
        .seconds      (seconds_reg),
        .segment      (segment_reg),
        .segment_empty(segment_empty_reg),
        .flags_in     (flags_reg),
        .seconds_out  (cl_seconds),
        .flags_out    (cl_flags)
    );

    always_comb
    begin
        seconds_next       = seconds_reg;
        segment_next       = segment_reg;
        segment_empty_next = segment_empty_reg;
        flags_next         = flags_reg;
        fdig_next          = fdig_reg;
        fval_next          = fval_reg;
        if (present_reg)
        begin
            case (char_reg) inside
                [tsms_pkg::CHAR_ZERO:tsms_pkg::CHAR_NINE]:
                begin
                    segment_next       = segment_digit;
                    segment_empty_next = 1'b0;
                    // only the first three digits count toward the fraction
                    if (fdig_reg < tsms_pkg::FDIG_W'(tsms_pkg::FRAC_DIGITS))
                    begin
                        fval_next = fval_reg * tsms_pkg::FVAL_W'(tsms_pkg::BASE_TEN)
                                  + tsms_pkg::FVAL_W'(digit);
                        fdig_next = fdig_reg + 1'b1;
                    end
                end
                tsms_pkg::CHAR_COLON:
                begin
                    seconds_next       = cl_seconds;
                    flags_next         = cl_flags;
                    segment_next       = '0;
                    segment_empty_next = 1'b1;
                    fdig_next          = '0;
                    fval_next          = '0;
                end
                tsms_pkg::CHAR_COMMA, tsms_pkg::CHAR_DOT:
                begin
                    seconds_next             = cl_seconds;
                    flags_next               = cl_flags;
                    flags_next.fraction_seen = 1'b1;
                    segment_next             = '0;
                    segment_empty_next       = 1'b1;
                    fdig_next                = '0;
                    fval_next                = '0;
                end
                default:
                begin
                    flags_next.bad_character = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            seconds_reg       <= '0;
            segment_reg       <= '0;
            segment_empty_reg <= 1'b1;
            flags_reg         <= '0;
            fdig_reg          <= '0;
            fval_reg          <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (process)
            begin
                if (last_reg)
                begin
                    // text handed to the final stages, start fresh
                    seconds_reg       <= '0;
                    segment_reg       <= '0;
                    segment_empty_reg <= 1'b1;
                    flags_reg         <= '0;
                    fdig_reg          <= '0;
                    fval_reg          <= '0;
                end
                else
                begin
                    seconds_reg       <= seconds_next;
                    segment_reg       <= segment_next;
                    segment_empty_reg <= segment_empty_next;
                    flags_reg         <= flags_next;
                    fdig_reg          <= fdig_next;
                    fval_reg          <= fval_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            char_reg    <= character;
            present_reg <= char_present;
            last_reg    <= last;
        end
    end

    tsms_final #(
        .TIME_BITS(TIME_BITS)
    ) u_final (
        .clk              (clk),
        .rst_n            (rst_n),
        .fin_valid        (process && last_reg),
        .fin_ready        (fin_ready),
        .fin_seconds      (seconds_next),
        .fin_segment      (segment_next),
        .fin_segment_empty(segment_empty_next),
        .fin_flags        (flags_next),
        .fin_fdig         (fdig_next),
        .fin_fval         (fval_next),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .valid_res        (valid_res),
        .milliseconds     (milliseconds)
    );

endmodule

// ===== bench/tsms_checker.sv =====
`timescale 1ns / 100ps
// tsms_checker: watches both channels of the timestamp parser, predicts each
// result word from the accepted input words and compares; depends on tsms_pkg
module tsms_checker #(
    parameter int TIME_BITS = 40
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [tsms_pkg::CHAR_W-1:0] character,
    input  logic                        char_present,
    input  logic                        last,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        valid_res,
    input  logic [tsms_pkg::MS_W-1:0]   milliseconds,
    output int                          mismatches,
    output int                          pending
);

    // 64-bit working words so the saturated segment (limit + 1) still fits
    localparam logic [63:0] VALUE_LIMIT = (64'd1 << TIME_BITS) - 64'd1;

    typedef struct packed {
        logic                      ok;
        logic [tsms_pkg::MS_W-1:0] ms;
    } verdict_t;

    verdict_t results_due[$];

    logic [63:0]                 secs_acc;
    logic [63:0]                 seg_acc;
    logic                        seg_empty;
    logic [tsms_pkg::PART_W-1:0] part_cnt;
    logic                        frac_seen;
    logic [tsms_pkg::FDIG_W-1:0] frac_cnt;
    logic [tsms_pkg::FVAL_W-1:0] frac_acc;
    logic                        bad_char;
    logic                        too_big;
    logic                        empty_part;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic void clear_segment();
        seg_acc   = '0;
        seg_empty = 1'b1;
        frac_cnt  = '0;
        frac_acc  = '0;
    endfunction

    function automatic void clear_text();
        secs_acc   = '0;
        part_cnt   = '0;
        frac_seen  = 1'b0;
        bad_char   = 1'b0;
        too_big    = 1'b0;
        empty_part = 1'b0;
        clear_segment();
    endfunction

    function automatic void close_part();
        if (seg_empty)
            empty_part = 1'b1;
        if (part_cnt < tsms_pkg::MAX_PARTS)
        begin
            if (seg_acc > VALUE_LIMIT ||
                secs_acc > (VALUE_LIMIT - seg_acc) / tsms_pkg::BASE_SIXTY)
                too_big = 1'b1;
            else
                secs_acc = secs_acc * tsms_pkg::BASE_SIXTY + seg_acc;
        end
        if (part_cnt < tsms_pkg::PART_SAT)
            part_cnt++;
        clear_segment();
    endfunction

    function automatic void take_char(input logic [tsms_pkg::CHAR_W-1:0] c);
        logic [63:0] d;
        d = 64'(c - tsms_pkg::CHAR_ZERO);
        if (c >= tsms_pkg::CHAR_ZERO && c <= tsms_pkg::CHAR_NINE)
        begin
            if (seg_acc > VALUE_LIMIT || seg_acc > (VALUE_LIMIT - d) / tsms_pkg::BASE_TEN)
                seg_acc = VALUE_LIMIT + 64'd1;
            else
                seg_acc = seg_acc * tsms_pkg::BASE_TEN + d;
            seg_empty = 1'b0;
            if (frac_cnt < tsms_pkg::FRAC_DIGITS)
            begin
                frac_acc = tsms_pkg::FVAL_W'(frac_acc * tsms_pkg::BASE_TEN + d);
                frac_cnt++;
            end
        end
        else if (c == tsms_pkg::CHAR_COLON)
            close_part();
        else if (c == tsms_pkg::CHAR_COMMA || c == tsms_pkg::CHAR_DOT)
        begin
            close_part();
            frac_seen = 1'b1;
        end
        else
            bad_char = 1'b1;
    endfunction

    function automatic verdict_t judge_text();
        logic [63:0] frac;
        verdict_t    v;
        frac = '0;
        if (frac_seen)
        begin
            // pad the fraction digits on the right to three places
            case (frac_cnt)
                2'd0:    frac = '0;
                2'd1:    frac = 64'(frac_acc) * tsms_pkg::BASE_TEN * tsms_pkg::BASE_TEN;
                2'd2:    frac = 64'(frac_acc) * tsms_pkg::BASE_TEN;
                default: frac = 64'(frac_acc);
            endcase
        end
        else
            close_part();
        v.ok = !bad_char && !too_big && !empty_part && part_cnt >= 1
            && part_cnt <= tsms_pkg::MAX_PARTS;
        v.ms = '0;
        if (v.ok)
        begin
            if (secs_acc > (VALUE_LIMIT - frac) / tsms_pkg::MS_PER_SEC)
                v.ok = 1'b0;
            else
                v.ms = tsms_pkg::MS_W'(secs_acc * tsms_pkg::MS_PER_SEC + frac);
        end
        clear_text();
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            clear_text();
            results_due.delete();
            mismatches = 0;
            pending <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (char_present)
                    take_char(character);
                if (last)
                    results_due.insert(results_due.size(), judge_text());
            end
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                    report("result word with nothing expected");
                else
                begin
                    want = results_due.pop_front();
                    if (valid_res !== want.ok)
                        report($sformatf("valid_res %b, expected %b", valid_res, want.ok));
                    if (milliseconds !== want.ms)
                        report($sformatf("milliseconds %0d, expected %0d",
                                         milliseconds, want.ms));
                end
            end
            pending <= results_due.size();
        end
    end

endmodule

// ===== bench/tb_timestamp_text_to_milliseconds.sv =====
`timescale 1ns / 100ps
// tb_timestamp_text_to_milliseconds: stimulus and verdict for the timestamp parser
// depends on tsms_pkg, the parser top level and tsms_checker
module tb_timestamp_text_to_milliseconds;

    localparam int TIME_BITS   = 40;
    localparam int ITEM_GOAL   = 800;
    localparam int IDLE_PCT    = 34;
    // cycles with no word moving on either channel before giving up
    localparam int STALL_LIMIT = 2000;
    // extra wait for the pipeline to drain once nothing is pending
    localparam int DRAIN_WAIT  = 8;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        in_valid     = 1'b0;
    logic [tsms_pkg::CHAR_W-1:0] character    = '0;
    logic                        char_present = 1'b0;
    logic                        last         = 1'b0;
    logic                        out_ready    = 1'b0;
    logic                        in_ready;
    logic                        out_valid;
    logic                        valid_res;
    logic [tsms_pkg::MS_W-1:0]   milliseconds;

    int          mismatches;
    int          pending;
    int          words_sent   = 0;
    int          quiet_cycles = 0;
    // no idling on either side while set
    logic        calm         = 1'b0;
    logic [7:0]  text_buf[$];

    always #6 clk = ~clk;

    timestamp_text_to_milliseconds #(
        .TIME_BITS(TIME_BITS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .character   (character),
        .char_present(char_present),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .valid_res   (valid_res),
        .milliseconds(milliseconds)
    );

    tsms_checker #(
        .TIME_BITS(TIME_BITS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .character   (character),
        .char_present(char_present),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .valid_res   (valid_res),
        .milliseconds(milliseconds),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // receiver stalls about a third of the cycles, never while calm
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    // watchdog: restarts whenever a word moves on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one input word; an optional idle gap first, then hold until accepted
    task automatic send_word(input logic [tsms_pkg::CHAR_W-1:0] c, input logic present,
                             input logic fin);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        character    <= c;
        char_present <= present;
        last         <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // sends text_buf as one text; bare_end closes it with a word carrying no character
    task automatic send_text(input logic bare_end);
        int n;
        n = text_buf.size();
        for (int i = 0; i < n; i++)
        begin
            // filler word: no character and not last, the parser ignores it
            if ($urandom_range(0, 99) < 4)
                send_word(tsms_pkg::CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_word(text_buf[i], 1'b1, !bare_end && i == n - 1);
        end
        if (bare_end || n == 0)
            send_word(tsms_pkg::CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b1);
        words_sent += n + ((bare_end || n == 0) ? 1 : 0);
        text_buf.delete();
    endtask

    task automatic add_byte(input logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endtask

    task automatic load_string(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic push_digits(input int n);
        repeat (n) add_byte(tsms_pkg::CHAR_W'(tsms_pkg::CHAR_ZERO + $urandom_range(0, 9)));
    endtask

    // well-formed text: one to three parts, usually short, now and then long
    // enough to overflow; mostly with a fraction of zero to four digits
    task automatic build_timestamp();
        int n_parts;
        n_parts = $urandom_range(1, tsms_pkg::MAX_PARTS);
        for (int p = 0; p < n_parts; p++)
        begin
            if (p > 0)
                add_byte(tsms_pkg::CHAR_COLON);
            if ($urandom_range(0, 99) < 4)
                push_digits($urandom_range(10, 14));
            else
                push_digits($urandom_range(1, 2));
        end
        if ($urandom_range(0, 99) < 70)
        begin
            add_byte($urandom_range(0, 1) ? tsms_pkg::CHAR_COMMA : tsms_pkg::CHAR_DOT);
            push_digits($urandom_range(0, 4));
            // separator after the fraction mark turns those digits into a part
            if ($urandom_range(0, 99) < 6)
            begin
                add_byte(tsms_pkg::CHAR_COLON);
                push_digits($urandom_range(0, 3));
            end
        end
    endtask

    // damage one spot: overwrite with any byte, add a separator, or drop a byte
    task automatic break_text();
        int           pos;
        logic [7:0]   sep;
        pos = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 2))
            0: text_buf[pos] = tsms_pkg::CHAR_W'($urandom_range(0, 255));
            1:
            begin
                case ($urandom_range(0, 2))
                    0:       sep = tsms_pkg::CHAR_COLON;
                    1:       sep = tsms_pkg::CHAR_COMMA;
                    default: sep = tsms_pkg::CHAR_DOT;
                endcase
                text_buf.insert(pos, sep);
            end
            default: text_buf.delete(pos);
        endcase
    endtask

    // loose bytes, half of them from the timestamp alphabet
    task automatic build_noise();
        string alphabet;
        alphabet = "0123456789:,.";
        repeat ($urandom_range(0, 5))
        begin
            if ($urandom_range(0, 1))
                add_byte(tsms_pkg::CHAR_W'($urandom_range(0, 255)));
            else
                add_byte(alphabet[$urandom_range(0, alphabet.len() - 1)]);
        end
    endtask

    initial
    begin
        int pick;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed texts
        load_string("1:2.3");   send_text(1'b0);   // hours-free with fraction
        load_string("5");       send_text(1'b0);   // single part
        send_text(1'b1);                           // empty text
        load_string("x");       send_text(1'b0);   // bad character
        add_byte(8'hFF);        send_text(1'b0);
        add_byte(8'h00);        send_text(1'b1);
        load_string("1:2:3:4"); send_text(1'b0);   // too many parts
        load_string(":");       send_text(1'b0);   // empty parts
        load_string(".5");      send_text(1'b0);   // empty part before fraction
        load_string("7,1234");  send_text(1'b0);   // fraction digits beyond three
        load_string("1.2:3");   send_text(1'b0);   // separator after fraction mark
        load_string("4.");      send_text(1'b1);   // empty fraction, bare end

        // random texts: mostly well-formed, some damaged, some noise
        while (words_sent < ITEM_GOAL)
        begin
            calm <= (words_sent >= 350 && words_sent < 500);
            pick = $urandom_range(0, 99);
            if (pick < 70)
                build_timestamp();
            else if (pick < 85)
            begin
                build_timestamp();
                break_text();
            end
            else
                build_noise();
            send_text($urandom_range(0, 99) < 20);
        end
        in_valid <= 1'b0;
        calm     <= 1'b0;

        // let the checker see the last word, then drain
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
